// ----- rtl/core/sgl_pkg.sv -----
`default_nettype none
package sgl_pkg;

  localparam int COORD_W    = 24;
  localparam int COUNT_W    = 5;
  localparam int CELL_IDX_W = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int RESULT_CAP = 64;
  localparam int NUM_W      = $clog2(RESULT_CAP + 1);
  localparam int ACC_W      = 64;
  localparam int MA_W       = 34;
  localparam int MB_W       = COORD_W + 1;

  typedef enum logic [1:0] {
    ST_CELL    = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_NONE    = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_AREA_WIDTH   = 3'd2,
    REG_AREA_HEIGHT  = 3'd3,
    REG_CELL_WIDTH   = 3'd4,
    REG_CELL_HEIGHT  = 3'd5,
    REG_COLUMN_TOTAL = 3'd6,
    REG_ROW_TOTAL    = 3'd7
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_DIV, S_CHK,
    S_MBX, S_WX, S_MNX, S_MDX,
    S_MBY, S_WY, S_MNY, S_MDY,
    S_T0, S_LOOP, S_SC, S_SR, S_TM, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    MOP_NONE, MOP_BX, MOP_NX, MOP_DX, MOP_BY, MOP_NY, MOP_DY
  } mop_t;

  typedef enum logic [1:0] {
    TS_NONE, TS_CUR, TS_SIDE_C, TS_SIDE_R
  } touch_sel_t;

  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] area_width;
    logic [COORD_W-1:0] area_height;
    logic [COORD_W-1:0] cell_width;
    logic [COORD_W-1:0] cell_height;
    logic [COUNT_W-1:0] column_total;
    logic [COUNT_W-1:0] row_total;
  } cfg_t;

  typedef struct packed {
    logic       load_item;
    logic       prep;
    logic       div_step;
    logic       init_walk;
    mop_t       mul_op;
    touch_sel_t touch_sel;
    logic       step_single;
    logic       step_corner;
    logic       budget_dec;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic reject;
    logic at_end;
    logic budget_zero;
    logic cap_hit;
    logic corner;
    logic touch_done;
    logic in_grid;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/sgl_if.sv -----
`default_nettype none
interface sgl_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] start_x;
  logic [23:0] start_y;
  logic [23:0] end_x;
  logic [23:0] end_y;
  logic        new_polyline;
  modport source (output valid, start_x, start_y, end_x, end_y, new_polyline, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, new_polyline, output ready);
endinterface

interface sgl_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] cell_row;
  logic [3:0] cell_column;
  logic [1:0] status;
  logic       last_of_segment;
  modport source (output valid, cell_row, cell_column, status, last_of_segment, input ready);
  modport sink   (input valid, cell_row, cell_column, status, last_of_segment, output ready);
endinterface

interface sgl_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/supercover_grid_line_walk.sv -----
// Supercover grid line walk: each input transaction is one polyline segment in
// unsigned Q16.8 pixels; the block walks the grid cells it crosses with an exact
// integer DDA, also taking both side neighbours where the segment passes exactly
// through a cell corner, and returns one transaction per newly touched cell (cells
// already produced since the last new_polyline are dropped). The final result of
// a segment carries last_of_segment; an endpoint outside the area, or an unusable
// grid, gives a single status 1 result, and a segment touching nothing new gives
// a single status 2 result. One segment at a time: the segment is taken and set
// up, then the endpoint index search runs on the four endpoint coordinates in
// parallel by repeated subtraction of the cell size, then a check that sends a
// rejected segment straight to the close, then the multiply schedule through the
// shared 34 x 25 multiplier for the crossing terms and the touch of the start
// cell. Each plain walk step is a decide and a touch; each corner step is a
// decide, both side neighbours and a touch. The walk stops on a decide that sees
// the end, the step budget or the result cap, or on a touch that leaves the
// grid, and then closes. Results leave through an output register, so the walk
// proceeds while the previous result waits for the consumer. Configuration is
// taken at any time but must only be written while the block is idle.
`default_nettype none
module supercover_grid_line_walk import sgl_pkg::*; #(
  parameter int MAX_ROWS    = 16,
  parameter int MAX_COLUMNS = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  sgl_in_if.sink    in_chan,
  sgl_out_if.source out_chan,
  sgl_cfg_if.sink   cfg_chan
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // register file: always ready, written by index
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x     <= '0;
      cfg_r.origin_y     <= '0;
      cfg_r.area_width   <= COORD_W'(256);
      cfg_r.area_height  <= COORD_W'(256);
      cfg_r.cell_width   <= COORD_W'(256);
      cfg_r.cell_height  <= COORD_W'(256);
      cfg_r.column_total <= COUNT_W'(16);
      cfg_r.row_total    <= COUNT_W'(16);
    end else if (cfg_chan.valid) begin
      case (cfg_reg_t'(cfg_chan.index))
        REG_ORIGIN_X:     cfg_r.origin_x     <= cfg_chan.data;
        REG_ORIGIN_Y:     cfg_r.origin_y     <= cfg_chan.data;
        REG_AREA_WIDTH:   cfg_r.area_width   <= cfg_chan.data;
        REG_AREA_HEIGHT:  cfg_r.area_height  <= cfg_chan.data;
        REG_CELL_WIDTH:   cfg_r.cell_width   <= cfg_chan.data;
        REG_CELL_HEIGHT:  cfg_r.cell_height  <= cfg_chan.data;
        REG_COLUMN_TOTAL: cfg_r.column_total <= cfg_chan.data[COUNT_W-1:0];
        REG_ROW_TOTAL:    cfg_r.row_total    <= cfg_chan.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: set-up, index search, multiply schedule, walk and close
  sgl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: endpoint mapping, crossing accumulators, visited map, output staging
  sgl_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .sts        (sts),
    .in_sx      (in_chan.start_x),
    .in_sy      (in_chan.start_y),
    .in_ex      (in_chan.end_x),
    .in_ey      (in_chan.end_y),
    .in_newpoly (in_chan.new_polyline),
    .out_ready  (out_chan.ready),
    .out_valid  (out_chan.valid),
    .out_row    (out_chan.cell_row),
    .out_col    (out_chan.cell_column),
    .out_status (out_chan.status),
    .out_last   (out_chan.last_of_segment)
  );

  assign in_chan.ready = in_ready;

  // a rejected or empty segment always closes the segment
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.status != ST_CELL) |-> out_chan.last_of_segment)
    else $error("non-cell status without last_of_segment");

  // empty and rejected results carry a zero cell
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.status != ST_CELL) |->
      (out_chan.cell_row == '0) && (out_chan.cell_column == '0))
    else $error("non-cell status with a non-zero cell");

  // one segment at a time: no new transaction straight after one is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("input taken while a segment is in progress");

endmodule
`default_nettype wire

// ----- rtl/core/sgl_dp.sv -----
`default_nettype none
module sgl_dp import sgl_pkg::*; #(
  parameter int MAX_ROWS    = 16,
  parameter int MAX_COLUMNS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cfg_t                  cfg,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  input  wire logic [COORD_W-1:0]    in_sx,
  input  wire logic [COORD_W-1:0]    in_sy,
  input  wire logic [COORD_W-1:0]    in_ex,
  input  wire logic [COORD_W-1:0]    in_ey,
  input  wire logic                  in_newpoly,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [CELL_IDX_W-1:0]      out_row,
  output logic [CELL_IDX_W-1:0]      out_col,
  output logic [1:0]                 out_status,
  output logic                       out_last
);

  localparam int MAXD = (MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS;
  localparam int CW   = $clog2(MAXD + 1);
  localparam int SW   = CW + 1;
  localparam int RIW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int BW   = $clog2((MAX_ROWS + MAX_COLUMNS) * 4 + 17);

  logic [COORD_W-1:0] sx_r, sy_r, ex_r, ey_r, adx_r, ady_r;
  logic               xpos_r, xneg_r, ypos_r, yneg_r, reject_r;
  logic [CW-1:0]      cols_used, rows_used;
  logic               ok, any_out;

  logic [COORD_W-1:0] rem_r [4];
  logic [CW-1:0]      idx_r [4];
  logic [3:0]         dn_r;
  logic [COORD_W-1:0] cell_a [4];
  logic [CW-1:0]      cnt_a [4];

  logic signed [MA_W-1:0]  ma, dist_r, bnd, dist_nxt;
  logic signed [MB_W-1:0]  mb;
  logic signed [MA_W+MB_W-1:0] mprod;
  logic signed [ACC_W-1:0] prod_r, nx_r, ny_r, dx_r, dy_r;
  mop_t                    mop_r;
  logic [CW:0]             kx, ky;

  logic signed [SW-1:0] r_r, c_r, dc, dr, tr, tc;
  logic [BW-1:0]        budget_r;
  logic [NUM_W-1:0]     n_r;
  logic [MAX_COLUMNS-1:0] vis_r [MAX_ROWS];
  logic                 in_grid, vbit, emit_need, can_push, touch_go, push;

  logic                  pend_valid_r, out_valid_r, out_last_r;
  logic [CELL_IDX_W-1:0] pend_row_r, pend_col_r, out_row_r, out_col_r;
  status_t               out_status_r;

  function automatic logic outside(input logic [COORD_W-1:0] p, org, len);
    return (p < org) || ({1'b0, p} > ({1'b0, org} + {1'b0, len}));
  endfunction

  always_comb begin
    cols_used = ({3'b0, cfg.column_total} > 8'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS)
                                                             : CW'(cfg.column_total);
    rows_used = ({3'b0, cfg.row_total} > 8'(MAX_ROWS)) ? CW'(MAX_ROWS)
                                                       : CW'(cfg.row_total);
    ok = (cols_used != '0) && (rows_used != '0) && (cfg.area_width != '0) &&
         (cfg.area_height != '0) && (cfg.cell_width != '0) && (cfg.cell_height != '0);
    any_out = outside(sx_r, cfg.origin_x, cfg.area_width) ||
              outside(ex_r, cfg.origin_x, cfg.area_width) ||
              outside(sy_r, cfg.origin_y, cfg.area_height) ||
              outside(ey_r, cfg.origin_y, cfg.area_height);
    cell_a[0] = cfg.cell_width;  cnt_a[0] = cols_used;
    cell_a[1] = cfg.cell_height; cnt_a[1] = rows_used;
    cell_a[2] = cfg.cell_width;  cnt_a[2] = cols_used;
    cell_a[3] = cfg.cell_height; cnt_a[3] = rows_used;
  end

  // shared multiplier operand select
  always_comb begin
    kx = xpos_r ? ({1'b0, idx_r[0]} + (CW+1)'(1)) : {1'b0, idx_r[0]};
    ky = ypos_r ? ({1'b0, idx_r[1]} + (CW+1)'(1)) : {1'b0, idx_r[1]};
    ma = '0;
    mb = '0;
    case (cmd.mul_op)
      MOP_BX: begin ma = $signed(MA_W'(kx)); mb = $signed({1'b0, cfg.cell_width}); end
      MOP_NX: begin ma = dist_r; mb = $signed({1'b0, ady_r}); end
      MOP_DX: begin ma = $signed(MA_W'(cfg.cell_width)); mb = $signed({1'b0, ady_r}); end
      MOP_BY: begin ma = $signed(MA_W'(ky)); mb = $signed({1'b0, cfg.cell_height}); end
      MOP_NY: begin ma = dist_r; mb = $signed({1'b0, adx_r}); end
      MOP_DY: begin ma = $signed(MA_W'(cfg.cell_height)); mb = $signed({1'b0, adx_r}); end
      default: begin ma = '0; mb = '0; end
    endcase
    mprod = ma * mb;
    if (mop_r == MOP_BY) begin
      bnd = $signed(MA_W'(cfg.origin_y)) + $signed(prod_r[MA_W-1:0]);
      dist_nxt = ypos_r ? (bnd - $signed(MA_W'(sy_r))) : ($signed(MA_W'(sy_r)) - bnd);
    end else begin
      bnd = $signed(MA_W'(cfg.origin_x)) + $signed(prod_r[MA_W-1:0]);
      dist_nxt = xpos_r ? (bnd - $signed(MA_W'(sx_r))) : ($signed(MA_W'(sx_r)) - bnd);
    end
  end

  // touch target and visited lookup
  always_comb begin
    dc = xpos_r ? SW'(1) : (xneg_r ? {SW{1'b1}} : '0);
    dr = ypos_r ? SW'(1) : (yneg_r ? {SW{1'b1}} : '0);
    tr = r_r;
    tc = c_r;
    case (cmd.touch_sel)
      TS_SIDE_C: tc = c_r + dc;
      TS_SIDE_R: tr = r_r + dr;
      default: begin tr = r_r; tc = c_r; end
    endcase
    in_grid = (tr >= 0) && (tc >= 0) && (tr < $signed({1'b0, rows_used})) &&
              (tc < $signed({1'b0, cols_used}));
    vbit = in_grid ? vis_r[tr[RIW-1:0]][tc[CIW-1:0]] : 1'b1;
    emit_need = in_grid && !vbit && (n_r < NUM_W'(RESULT_CAP));
    can_push = !pend_valid_r || !out_valid_r || out_ready;
    touch_go = (cmd.touch_sel != TS_NONE) && (!emit_need || can_push);
    push = touch_go && emit_need;
  end

  always_comb begin
    sts.div_done    = &dn_r;
    sts.reject      = reject_r;
    sts.at_end      = (r_r == $signed({1'b0, idx_r[3]})) && (c_r == $signed({1'b0, idx_r[2]}));
    sts.budget_zero = (budget_r == '0);
    sts.cap_hit     = (n_r >= NUM_W'(RESULT_CAP));
    sts.corner      = (xpos_r || xneg_r) && (ypos_r || yneg_r) && (nx_r == ny_r);
    sts.touch_done  = !emit_need || can_push;
    sts.in_grid     = in_grid;
    sts.out_free    = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      sx_r <= in_sx; sy_r <= in_sy; ex_r <= in_ex; ey_r <= in_ey;
    end
    if (cmd.prep) begin
      xpos_r <= ex_r > sx_r; xneg_r <= ex_r < sx_r;
      ypos_r <= ey_r > sy_r; yneg_r <= ey_r < sy_r;
      adx_r <= (ex_r > sx_r) ? (ex_r - sx_r) : (sx_r - ex_r);
      ady_r <= (ey_r > sy_r) ? (ey_r - sy_r) : (sy_r - ey_r);
      reject_r <= !ok || any_out;
      rem_r[0] <= sx_r - cfg.origin_x; rem_r[1] <= sy_r - cfg.origin_y;
      rem_r[2] <= ex_r - cfg.origin_x; rem_r[3] <= ey_r - cfg.origin_y;
      for (int k = 0; k < 4; k++) idx_r[k] <= '0;
    end
    if (cmd.div_step) begin
      for (int k = 0; k < 4; k++) begin
        if (!dn_r[k] && ((idx_r[k] + CW'(1)) < cnt_a[k]) && (rem_r[k] >= cell_a[k])) begin
          rem_r[k] <= rem_r[k] - cell_a[k];
          idx_r[k] <= idx_r[k] + CW'(1);
        end
      end
    end
    prod_r <= ACC_W'(mprod);
    case (mop_r)
      MOP_BX, MOP_BY: dist_r <= dist_nxt;
      MOP_NX: nx_r <= prod_r;
      MOP_DX: dx_r <= prod_r;
      MOP_NY: ny_r <= prod_r;
      MOP_DY: dy_r <= prod_r;
      default: ;
    endcase
    if (cmd.init_walk) begin
      r_r <= $signed({1'b0, idx_r[1]});
      c_r <= $signed({1'b0, idx_r[0]});
    end else if (cmd.step_corner) begin
      r_r <= r_r + dr; c_r <= c_r + dc;
      nx_r <= nx_r + dx_r; ny_r <= ny_r + dy_r;
    end else if (cmd.step_single) begin
      if (!(ypos_r || yneg_r) || ((xpos_r || xneg_r) && (nx_r < ny_r))) begin
        c_r <= c_r + dc; nx_r <= nx_r + dx_r;
      end else begin
        r_r <= r_r + dr; ny_r <= ny_r + dy_r;
      end
    end
    if (push) begin
      pend_row_r <= CELL_IDX_W'(tr);
      pend_col_r <= CELL_IDX_W'(tc);
    end
    if (push && pend_valid_r) begin
      out_row_r <= pend_row_r; out_col_r <= pend_col_r;
      out_status_r <= ST_CELL; out_last_r <= 1'b0;
    end else if (cmd.finish) begin
      out_last_r <= 1'b1;
      if (reject_r) begin
        out_row_r <= '0; out_col_r <= '0; out_status_r <= ST_OUTSIDE;
      end else if (pend_valid_r) begin
        out_row_r <= pend_row_r; out_col_r <= pend_col_r; out_status_r <= ST_CELL;
      end else begin
        out_row_r <= '0; out_col_r <= '0; out_status_r <= ST_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_r <= '0;
      mop_r <= MOP_NONE;
      budget_r <= '0;
      n_r <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_ROWS; i++) vis_r[i] <= '0;
    end else begin
      mop_r <= cmd.mul_op;
      if (cmd.prep) dn_r <= '0;
      else if (cmd.div_step) begin
        for (int k = 0; k < 4; k++)
          if (!(((idx_r[k] + CW'(1)) < cnt_a[k]) && (rem_r[k] >= cell_a[k]))) dn_r[k] <= 1'b1;
      end
      if (cmd.load_item) begin
        n_r <= '0;
        if (in_newpoly) for (int i = 0; i < MAX_ROWS; i++) vis_r[i] <= '0;
      end
      if (cmd.init_walk)
        budget_r <= BW'((32'(rows_used) + 32'(cols_used)) * 32'd4 + 32'd16);
      else if (cmd.budget_dec)
        budget_r <= budget_r - BW'(1);
      if (push) begin
        vis_r[tr[RIW-1:0]][tc[CIW-1:0]] <= 1'b1;
        n_r <= n_r + NUM_W'(1);
        pend_valid_r <= 1'b1;
      end else if (cmd.finish) begin
        pend_valid_r <= 1'b0;
      end
      if ((push && pend_valid_r) || cmd.finish) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

// ----- rtl/core/sgl_ctrl.sv -----
`default_nettype none
module sgl_ctrl import sgl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.mul_op = MOP_NONE;
    cmd.touch_sel = TS_NONE;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.init_walk = 1'b1;
        state_nxt = sts.reject ? S_FIN : S_MBX;
      end
      S_MBX: begin cmd.mul_op = MOP_BX; state_nxt = S_WX;  end
      S_WX:  state_nxt = S_MNX;
      S_MNX: begin cmd.mul_op = MOP_NX; state_nxt = S_MDX; end
      S_MDX: begin cmd.mul_op = MOP_DX; state_nxt = S_MBY; end
      S_MBY: begin cmd.mul_op = MOP_BY; state_nxt = S_WY;  end
      S_WY:  state_nxt = S_MNY;
      S_MNY: begin cmd.mul_op = MOP_NY; state_nxt = S_MDY; end
      S_MDY: begin cmd.mul_op = MOP_DY; state_nxt = S_T0;  end
      S_T0: begin
        cmd.touch_sel = TS_CUR;
        if (sts.touch_done) state_nxt = S_LOOP;
      end
      S_LOOP: begin
        if (sts.at_end || sts.budget_zero || sts.cap_hit) begin
          state_nxt = S_FIN;
        end else if (sts.corner) begin
          cmd.budget_dec = 1'b1;
          state_nxt = S_SC;
        end else begin
          cmd.budget_dec = 1'b1;
          cmd.step_single = 1'b1;
          state_nxt = S_TM;
        end
      end
      S_SC: begin
        cmd.touch_sel = TS_SIDE_C;
        if (sts.touch_done) state_nxt = S_SR;
      end
      S_SR: begin
        cmd.touch_sel = TS_SIDE_R;
        if (sts.touch_done) begin
          cmd.step_corner = 1'b1;
          state_nxt = S_TM;
        end
      end
      S_TM: begin
        cmd.touch_sel = TS_CUR;
        if (sts.touch_done) state_nxt = sts.in_grid ? S_LOOP : S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire
